/* rtl/core/sobel5_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the 5x5 gradient-magnitude edge core.
// No dependencies; every other file in rtl/core refers to this package by scope.
package sobel5_pkg;

    localparam int KERNEL_SIZE = 5;
    localparam int LINES       = KERNEL_SIZE - 1;
    localparam int PIX_W       = 8;

    localparam int MAX_WIDTH_DEF = 512;
    localparam int MAX_HEIGHT    = 4096;
    localparam int MIN_DIM       = KERNEL_SIZE;

    // Frame geometry registers and counters
    localparam int FW_W        = 10;
    localparam int FH_W        = 13;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 12;
    localparam int DIM_W       = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 1;
    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 10'd500;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd500;

    // Datapath widths
    localparam int VS_W      = 12;                 // vertical smoothing, max 10*255
    localparam int DS_W      = 11;                 // vertical derivative, +/-3*255
    localparam int SUM_W     = 14;                 // full kernel sums, +/-7650
    localparam int DIV_SHIFT = 7;                  // divide by 128
    localparam int Q_W       = SUM_W - DIV_SHIFT;
    localparam int RAD_W     = 2 * Q_W;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int MAG_W     = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef pixel_t [KERNEL_SIZE-1:0] column_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_RUN,
        SQ_DONE
    } sqrt_state_t;

    typedef struct packed {
        logic             start;
        logic             last;
        logic [RAD_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic              last;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

endpackage

/* rtl/core/sobel_5x5_edge_magnitude_core.sv */
`timescale 1ns / 1ps
// Top level of the 5x5 gradient-magnitude edge core: frame counters, config
// registers, output register. Needs sobel5_pkg, sobel5_line_mem, sobel5_grad, sobel5_isqrt.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------
//  in       | in_valid / in_stall        | pixel[7:0]
//  out      | out_valid / out_stall      | magnitude[7:0], last
//  cfg      | cfg_write (no wait)        | cfg_index[0], cfg_data[12:0]
//
// A border pixel (no result) does not hold the input; such items go back to back
// unless an interior item ahead holds it. An interior pixel holds the input after
// acceptance through the column stage, kernel sum, square and 7 iterations of the
// square-root unit, until its result is handed to the output register.
// The output register frees the datapath: a held result does not block input
// until the next interior item finishes. Reset sets width and height to 500 and
// clears the frame counters; the line store needs no clearing pass.
module sobel_5x5_edge_magnitude_core #(
    parameter int MAX_WIDTH = sobel5_pkg::MAX_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [sobel5_pkg::PIX_W-1:0]       pixel,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [sobel5_pkg::MAG_W-1:0]       magnitude,
    output logic                               last,
    input  logic                               cfg_write,
    input  logic [sobel5_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sobel5_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int DIM_W  = sobel5_pkg::DIM_W;

    logic [sobel5_pkg::FW_W-1:0]  frame_width_reg;
    logic [sobel5_pkg::FH_W-1:0]  frame_height_reg;
    logic [sobel5_pkg::COL_W-1:0] col_cnt_reg;
    logic [sobel5_pkg::COL_W-1:0] col_cnt_next;
    logic [sobel5_pkg::ROW_W-1:0] row_cnt_reg;
    logic [sobel5_pkg::ROW_W-1:0] row_cnt_next;
    logic                         a_emit_reg;
    logic                         a_last_reg;
    logic                         out_valid_reg;
    logic [sobel5_pkg::MAG_W-1:0] magnitude_reg;
    logic                         last_reg;

    logic [DIM_W-1:0] fw;
    logic [DIM_W-1:0] fh;
    logic [DIM_W-1:0] w_use;
    logic [DIM_W-1:0] h_use;
    logic             last_col;
    logic             last_row;
    logic             emit;
    logic             in_acc;
    logic             out_load;

    logic                  col_valid;
    sobel5_pkg::column_t   column;
    sobel5_pkg::sqrt_req_t sq_req;
    sobel5_pkg::sqrt_rsp_t sq_rsp;
    logic                  grad_busy;

    // Geometry in use: clamp both registers to the supported range
    always_comb
    begin
        fw = DIM_W'(frame_width_reg);
        fh = DIM_W'(frame_height_reg);
        if (fw < DIM_W'(sobel5_pkg::MIN_DIM))
            w_use = DIM_W'(sobel5_pkg::MIN_DIM);
        else if (fw > DIM_W'(MAX_WIDTH))
            w_use = DIM_W'(MAX_WIDTH);
        else
            w_use = fw;
        if (fh < DIM_W'(sobel5_pkg::MIN_DIM))
            h_use = DIM_W'(sobel5_pkg::MIN_DIM);
        else if (fh > DIM_W'(sobel5_pkg::MAX_HEIGHT))
            h_use = DIM_W'(sobel5_pkg::MAX_HEIGHT);
        else
            h_use = fh;
    end

    always_comb
    begin
        last_col = (DIM_W'(col_cnt_reg) + 1'b1) >= w_use;
        last_row = (DIM_W'(row_cnt_reg) + 1'b1) >= h_use;
        emit     = (row_cnt_reg >= sobel5_pkg::ROW_W'(sobel5_pkg::LINES))
                && (col_cnt_reg >= sobel5_pkg::COL_W'(sobel5_pkg::LINES));
        if (last_col)
        begin
            col_cnt_next = '0;
            row_cnt_next = last_row ? '0 : row_cnt_reg + 1'b1;
        end
        else
        begin
            col_cnt_next = col_cnt_reg + 1'b1;
            row_cnt_next = row_cnt_reg;
        end
    end

    // Hold input while an interior item is anywhere past the line store
    assign in_stall = a_emit_reg || grad_busy || sq_rsp.busy;
    assign in_acc   = in_valid && !in_stall;
    assign out_load = sq_rsp.done && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= sobel5_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= sobel5_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sobel5_pkg::REG_FRAME_WIDTH:
                begin
                    frame_width_reg <= cfg_data[sobel5_pkg::FW_W-1:0];
                end
                sobel5_pkg::REG_FRAME_HEIGHT:
                begin
                    frame_height_reg <= cfg_data[sobel5_pkg::FH_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            a_emit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
            a_emit_reg <= in_acc && emit;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_last_reg <= last_col && last_row;
        end
        // Root never exceeds 83 at 8-bit input, so no saturation is needed
        if (out_load)
        begin
            magnitude_reg <= sobel5_pkg::MAG_W'(sq_rsp.root);
            last_reg      <= sq_rsp.last;
        end
    end

    sobel5_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (in_acc),
        .addr      (ADDR_W'(col_cnt_reg)),
        .pixel     (pixel),
        .col_valid (col_valid),
        .column    (column)
    );

    sobel5_grad u_grad (
        .clk       (clk),
        .rst_n     (rst_n),
        .col_valid (col_valid),
        .column    (column),
        .emit      (a_emit_reg),
        .last      (a_last_reg),
        .req       (sq_req),
        .busy      (grad_busy)
    );

    sobel5_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .take  (out_load),
        .rsp   (sq_rsp)
    );

    assign out_valid = out_valid_reg;
    assign magnitude = magnitude_reg;
    assign last      = last_reg;

`ifndef SYNTH
    a_no_accept_while_root_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> !sq_rsp.busy)
        else $error("item accepted while the square-root unit is busy");

    a_result_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        sq_rsp.done && !out_load |=> sq_rsp.done)
        else $error("finished root dropped before reaching the output register");

    a_column_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        DIM_W'(col_cnt_reg) < DIM_W'(MAX_WIDTH))
        else $error("column count beyond line store depth");
`endif

endmodule

/* rtl/core/sobel5_line_mem.sv */
`timescale 1ns / 1ps
// Four-line pixel store: one synchronous memory, one entry per column holding
// four stacked pixels. Read on accept, write back in the following cycle. Uses sobel5_pkg.
module sobel5_line_mem #(
    parameter int MAX_WIDTH = sobel5_pkg::MAX_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     acc,
    input  logic [$clog2(MAX_WIDTH)-1:0] addr,
    input  sobel5_pkg::pixel_t       pixel,
    output logic                     col_valid,
    output sobel5_pkg::column_t      column
);

    localparam int ADDR_W  = $clog2(MAX_WIDTH);
    localparam int ENTRY_W = sobel5_pkg::LINES * sobel5_pkg::PIX_W;

    logic [ENTRY_W-1:0] mem [MAX_WIDTH];
    logic [ENTRY_W-1:0] rdata_reg;
    logic [ADDR_W-1:0]  addr_reg;
    sobel5_pkg::pixel_t pixel_reg;
    logic               valid_reg;
    logic [ENTRY_W-1:0] wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rdata_reg <= mem[addr];
            addr_reg  <= addr;
            pixel_reg <= pixel;
        end
        if (valid_reg)
        begin
            mem[addr_reg] <= wdata;
        end
    end

    // Oldest line sits in the low byte; the new pixel closes the column.
    always_comb
    begin
        for (int y = 0; y < sobel5_pkg::LINES; y++)
        begin
            column[y] = rdata_reg[y*sobel5_pkg::PIX_W +: sobel5_pkg::PIX_W];
        end
        column[sobel5_pkg::LINES] = pixel_reg;
        // Shift every line up by one row.
        for (int y = 0; y < sobel5_pkg::LINES; y++)
        begin
            wdata[y*sobel5_pkg::PIX_W +: sobel5_pkg::PIX_W] = column[y+1];
        end
    end

    assign col_valid = valid_reg;

`ifndef SYNTH
    // Read of a column while its write-back is pending would return stale pixels.
    a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        acc && valid_reg |-> addr != addr_reg)
        else $error("line store read hits the entry being written back");
`endif

endmodule

/* rtl/core/sobel5_grad.sv */
`timescale 1ns / 1ps
// Gradient datapath: column sums into a 5-column window, kernel sums,
// divide by 128 toward zero and sum of squares. Uses sobel5_pkg.
module sobel5_grad (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  col_valid,
    input  sobel5_pkg::column_t   column,
    input  logic                  emit,
    input  logic                  last,
    output sobel5_pkg::sqrt_req_t req,
    output logic                  busy
);

    localparam int K = sobel5_pkg::KERNEL_SIZE;

    // Window kept as per-column smoothing and derivative sums (kernels are separable)
    logic        [sobel5_pkg::VS_W-1:0]  vs_reg [K];
    logic signed [sobel5_pkg::DS_W-1:0]  ds_reg [K];
    logic signed [sobel5_pkg::SUM_W-1:0] sx_reg;
    logic signed [sobel5_pkg::SUM_W-1:0] sy_reg;
    logic                                s_valid_reg;
    logic                                s_last_reg;
    logic                                q_valid_reg;
    logic                                q_last_reg;

    logic        [sobel5_pkg::VS_W-1:0]  ce [K];
    logic signed [sobel5_pkg::DS_W-1:0]  de [K];
    logic        [sobel5_pkg::VS_W-1:0]  vs_new;
    logic signed [sobel5_pkg::DS_W-1:0]  ds_new;
    logic signed [sobel5_pkg::SUM_W-1:0] vx [K];
    logic signed [sobel5_pkg::SUM_W-1:0] dx [K];
    logic signed [sobel5_pkg::SUM_W-1:0] sx_next;
    logic signed [sobel5_pkg::SUM_W-1:0] sy_next;
    logic        [sobel5_pkg::SUM_W-1:0] ax;
    logic        [sobel5_pkg::SUM_W-1:0] ay;
    logic        [sobel5_pkg::Q_W-1:0]   qx;
    logic        [sobel5_pkg::Q_W-1:0]   qy;
    logic        [sobel5_pkg::RAD_W-1:0] sqx;
    logic        [sobel5_pkg::RAD_W-1:0] sqy;

    // Column sums: weights 1 2 4 2 1 and -1 -2 0 2 1 down the column
    always_comb
    begin
        for (int y = 0; y < K; y++)
        begin
            ce[y] = sobel5_pkg::VS_W'(column[y]);
            de[y] = signed'(sobel5_pkg::DS_W'(column[y]));
        end
        vs_new = ce[0] + ce[4] + ((ce[1] + ce[3]) << 1) + (ce[2] << 2);
        ds_new = (de[4] - de[0]) + ((de[3] - de[1]) <<< 1);
    end

    // Row sums across the window give the two kernel responses
    always_comb
    begin
        for (int x = 0; x < K; x++)
        begin
            vx[x] = signed'(sobel5_pkg::SUM_W'(vs_reg[x]));
            dx[x] = sobel5_pkg::SUM_W'(ds_reg[x]);
        end
        sx_next = (vx[4] - vx[0]) + ((vx[3] - vx[1]) <<< 1);
        sy_next = dx[0] + dx[4] + ((dx[1] + dx[3]) <<< 1) + (dx[2] <<< 2);
    end

    // Truncate toward zero on the magnitude, then square
    always_comb
    begin
        ax  = sx_reg[sobel5_pkg::SUM_W-1] ? sobel5_pkg::SUM_W'(-sx_reg)
                                          : sobel5_pkg::SUM_W'(sx_reg);
        ay  = sy_reg[sobel5_pkg::SUM_W-1] ? sobel5_pkg::SUM_W'(-sy_reg)
                                          : sobel5_pkg::SUM_W'(sy_reg);
        qx  = sobel5_pkg::Q_W'(ax >> sobel5_pkg::DIV_SHIFT);
        qy  = sobel5_pkg::Q_W'(ay >> sobel5_pkg::DIV_SHIFT);
        sqx = sobel5_pkg::RAD_W'(qx) * sobel5_pkg::RAD_W'(qx);
        sqy = sobel5_pkg::RAD_W'(qy) * sobel5_pkg::RAD_W'(qy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= col_valid && emit;
            q_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (col_valid)
        begin
            // Advance the window: newest column enters on the right
            for (int x = 0; x < K - 1; x++)
            begin
                vs_reg[x] <= vs_reg[x+1];
                ds_reg[x] <= ds_reg[x+1];
            end
            vs_reg[K-1] <= vs_new;
            ds_reg[K-1] <= ds_new;
            s_last_reg  <= last;
        end
        if (s_valid_reg)
        begin
            sx_reg     <= sx_next;
            sy_reg     <= sy_next;
            q_last_reg <= s_last_reg;
        end
    end

    // Sum of two squares of at most 59 stays well inside the radicand width
    assign req.start    = q_valid_reg;
    assign req.last     = q_last_reg;
    assign req.radicand = sqx + sqy;
    assign busy         = s_valid_reg || q_valid_reg;

endmodule

/* rtl/core/sobel5_isqrt.sv */
`timescale 1ns / 1ps
// Iterative integer square root, two radicand bits per cycle, result held
// until taken. Uses sobel5_pkg for widths, request/response structs and states.
module sobel5_isqrt (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sobel5_pkg::sqrt_req_t req,
    input  logic                  take,
    output sobel5_pkg::sqrt_rsp_t rsp
);

    localparam int RAD_W  = sobel5_pkg::RAD_W;
    localparam int ROOT_W = sobel5_pkg::ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int STEP_W = $clog2(ROOT_W);

    sobel5_pkg::sqrt_state_t state_reg;
    sobel5_pkg::sqrt_state_t state_next;

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [STEP_W-1:0] step_reg;
    logic              last_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sobel5_pkg::SQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rsp.busy   = 1'b1;
        rsp.done   = 1'b0;
        rsp.last   = last_reg;
        rsp.root   = root_reg;
        case (state_reg)
            sobel5_pkg::SQ_IDLE:
            begin
                rsp.busy = 1'b0;
                if (req.start)
                begin
                    state_next = sobel5_pkg::SQ_RUN;
                end
            end
            sobel5_pkg::SQ_RUN:
            begin
                if (step_reg == '0)
                begin
                    state_next = sobel5_pkg::SQ_DONE;
                end
            end
            sobel5_pkg::SQ_DONE:
            begin
                rsp.done = 1'b1;
                if (take)
                begin
                    state_next = sobel5_pkg::SQ_IDLE;
                end
            end
            default:
            begin
                state_next = sobel5_pkg::SQ_IDLE;
            end
        endcase
    end

    // One restoring step: bring down two bits, try root*4+1
    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial  = {root_reg, 2'b01};
        fits   = rem_sh >= trial;
    end

    always_ff @(posedge clk)
    begin
        if (req.start && state_reg == sobel5_pkg::SQ_IDLE)
        begin
            rad_reg  <= req.radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= STEP_W'(ROOT_W - 1);
            last_reg <= req.last;
        end
        else if (state_reg == sobel5_pkg::SQ_RUN)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
            step_reg <= step_reg - 1'b1;
        end
    end

`ifndef SYNTH
    // The front end must hold new work while a root is in progress or unread.
    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == sobel5_pkg::SQ_IDLE)
        else $error("square root started while busy");
`endif

endmodule

/* test/sobel5_magnitude_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the 5x5 gradient-magnitude edge core: watches the pixel, result and
// register ports, predicts every edge magnitude and compares it. Needs sobel5_pkg.
module sobel5_magnitude_checker #(
    parameter int MAX_WIDTH = sobel5_pkg::MAX_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [sobel5_pkg::PIX_W-1:0]       pixel,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [sobel5_pkg::MAG_W-1:0]       magnitude,
    input  logic                               last,
    input  logic                               cfg_write,
    input  logic [sobel5_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sobel5_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 results_seen
);
    import sobel5_pkg::*;

    localparam int MAG_MAX = (1 << MAG_W) - 1;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             last;
    } edge_result_t;

    pixel_t           line_mem [LINES][MAX_WIDTH];
    pixel_t           win [KERNEL_SIZE][KERNEL_SIZE];
    logic [COL_W-1:0] col_cnt;
    logic [ROW_W-1:0] row_cnt;
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    edge_result_t     expected_mags [$];
    int               errors;
    int               seen;

    // Both kernels are separable: a 1-2-4-2-1 smoothing tap times a -1,-2,0,2,1 slope tap.
    function automatic int smooth_tap(input int i);
        case (i)
            0, 4:    return 1;
            1, 3:    return 2;
            default: return 4;
        endcase
    endfunction

    function automatic int slope_tap(input int i);
        case (i)
            0:       return -1;
            1:       return -2;
            3:       return 2;
            4:       return 1;
            default: return 0;
        endcase
    endfunction

    function automatic int int_sqrt(input int radicand);
        int root;
        int trial;
        root = 0;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        return root;
    endfunction

    task automatic compute_edge_magnitude(input pixel_t px);
        pixel_t       column [KERNEL_SIZE];
        int           w;
        int           h;
        int           slot;
        int           sx;
        int           sy;
        int           qx;
        int           qy;
        int           root;
        logic         emit;
        logic         end_col;
        logic         end_row;
        edge_result_t res;

        w = width_reg;
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = height_reg;
        if (h < MIN_DIM) h = MIN_DIM;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        slot = int'(col_cnt) % MAX_WIDTH;

        // read the vertical column, then push the line stores up one row
        for (int y = 0; y < LINES; y++)
            column[y] = line_mem[y][slot];
        column[LINES] = px;
        for (int y = 0; y < LINES; y++)
            line_mem[y][slot] = column[y + 1];

        for (int y = 0; y < KERNEL_SIZE; y++) begin
            for (int x = 0; x < KERNEL_SIZE - 1; x++)
                win[y][x] = win[y][x + 1];
            win[y][KERNEL_SIZE - 1] = column[y];
        end

        emit    = (int'(row_cnt) >= LINES) && (int'(col_cnt) >= LINES);
        end_col = (int'(col_cnt) + 1 >= w);
        end_row = (int'(row_cnt) + 1 >= h);

        if (emit) begin
            sx = 0;
            sy = 0;
            for (int y = 0; y < KERNEL_SIZE; y++) begin
                for (int x = 0; x < KERNEL_SIZE; x++) begin
                    sx += int'(win[y][x]) * smooth_tap(y) * slope_tap(x);
                    sy += int'(win[y][x]) * slope_tap(y) * smooth_tap(x);
                end
            end
            // integer division truncates toward zero, sign is kept
            qx   = sx / (1 << DIV_SHIFT);
            qy   = sy / (1 << DIV_SHIFT);
            root = int_sqrt(qx * qx + qy * qy);
            if (root > MAG_MAX)
                root = MAG_MAX;
            res.magnitude = root[MAG_W-1:0];
            res.last      = end_col && end_row;
            expected_mags.push_back(res);
        end

        if (end_col) begin
            col_cnt = '0;
            if (end_row)
                row_cnt = '0;
            else
                row_cnt = row_cnt + 1'b1;
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        edge_result_t want;
        if (!rst_n) begin
            for (int y = 0; y < KERNEL_SIZE; y++)
                for (int x = 0; x < KERNEL_SIZE; x++)
                    win[y][x] = '0;
            col_cnt    = '0;
            row_cnt    = '0;
            width_reg  = FRAME_WIDTH_RESET;
            height_reg = FRAME_HEIGHT_RESET;
            expected_mags.delete();
            errors = 0;
            seen   = 0;
            fail_count   <= 0;
            pending      <= 0;
            results_seen <= 0;
        end else begin
            // a result can never belong to a pixel taken at the same edge: check first
            if (out_valid && !out_stall) begin
                seen++;
                if (expected_mags.size() == 0) begin
                    $error("magnitude: expected none, got %0d", magnitude);
                    errors++;
                end else begin
                    want = expected_mags.pop_front();
                    if (magnitude !== want.magnitude) begin
                        $error("magnitude: expected %0d, got %0d", want.magnitude, magnitude);
                        errors++;
                    end
                    if (last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        errors++;
                    end
                end
            end
            if (cfg_write) begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  = cfg_data[FW_W-1:0];
                    REG_FRAME_HEIGHT: height_reg = cfg_data[FH_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                compute_edge_magnitude(pixel);
            fail_count   <= errors;
            pending      <= expected_mags.size();
            results_seen <= seen;
        end
    end

endmodule

/* test/sobel_5x5_edge_magnitude_core_test.sv */
`timescale 1ns / 1ps
// Top of the edge core test: clock, reset, pixel frames, register writes and output
// back-pressure, plus the verdict. Needs sobel5_pkg, the core and sobel5_magnitude_checker.
module sobel_5x5_edge_magnitude_core_test;
    import sobel5_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 24;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1100;

    typedef enum int {
        STYLE_UNIFORM,
        STYLE_BINARY,
        STYLE_VSTEP,
        STYLE_HSTEP,
        STYLE_NOISE
    } frame_style_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    pixel_t                 pixel;
    logic                   out_valid;
    logic                   out_stall;
    logic [MAG_W-1:0]       magnitude;
    logic                   last;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int pending;
    int results_seen;

    int           send_idle_pct = 30;
    int           recv_idle_pct = 60;
    logic         long_hold     = 1'b0;
    bit           hold_served   = 1'b0;
    int           quiet_cycles  = 0;
    int           items_sent    = 0;
    int           frames_sent   = 0;
    int           pos_col       = 0;
    int           pos_row       = 0;
    int           width_used    = FRAME_WIDTH_RESET;
    int           height_used   = FRAME_HEIGHT_RESET;
    frame_style_t frame_style   = STYLE_UNIFORM;
    int           edge_pos      = 2;
    pixel_t       noise_level   = '0;

    sobel_5x5_edge_magnitude_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .magnitude (magnitude),
        .last      (last),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sobel5_magnitude_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .magnitude    (magnitude),
        .last         (last),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int clamp_dim(input int value, input int hi);
        if (value < MIN_DIM)
            return MIN_DIM;
        if (value > hi)
            return hi;
        return value;
    endfunction

    function automatic pixel_t pick_pixel(input int c, input int r);
        case (frame_style)
            STYLE_BINARY: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            STYLE_VSTEP:  return (c < edge_pos) ? 8'hFF : 8'h00;
            STYLE_HSTEP:  return (r < edge_pos) ? 8'h00 : 8'hFF;
            STYLE_NOISE:  return noise_level + pixel_t'($urandom_range(3));
            default:      return pixel_t'($urandom_range(255));
        endcase
    endfunction

    // Offer one item, idling first at random; advance the frame position on acceptance.
    task automatic push_pixel(input pixel_t value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= value;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (pos_col + 1 >= width_used)
        begin
            pos_col = 0;
            if (pos_row + 1 >= height_used)
            begin
                pos_row = 0;
                frames_sent++;
            end
            else
            begin
                pos_row++;
            end
        end
        else
        begin
            pos_col++;
        end
    endtask

    task automatic send_pixels(input int count);
        repeat (count) push_pixel(pick_pixel(pos_col, pos_row));
    endtask

    // Run to the end of the current frame, or through a whole one from its start.
    task automatic finish_frame();
        do push_pixel(pick_pixel(pos_col, pos_row));
        while (pos_col != 0 || pos_row != 0);
    endtask

    // Hold the input until every predicted result is out, then let the pipe settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame(input int width_raw, input int height_raw);
        logic [CFG_DATA_W-1:0] word;
        word            = CFG_DATA_W'($urandom);
        word[FW_W-1:0]  = width_raw[FW_W-1:0];
        width_used      = clamp_dim(int'(word[FW_W-1:0]), MAX_WIDTH_DEF);
        cfg_write <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= word;
        @(posedge clk);
        word        = height_raw[CFG_DATA_W-1:0];
        height_used = clamp_dim(int'(word), MAX_HEIGHT);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= word;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Output side: random stall, with one long hold-off once it is requested.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold && !hold_served)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_served = 1'b1;
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** sobel_5x5_edge_magnitude_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int directed_items;
        int width_raw;
        int height_raw;
        int rand_done;

        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        pixel     = '0;
        cfg_write = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // start a row at the reset geometry, then shrink to 5x5 mid-frame
        frame_style = STYLE_VSTEP;
        edge_pos    = 2;
        send_pixels(12);
        drain_results();
        set_frame(5, 5);
        finish_frame();
        drain_results();

        // below-range values clamp to the kernel size
        set_frame(0, 3);
        frame_style = STYLE_BINARY;
        finish_frame();
        drain_results();

        // all width bits set: clamps to the widest row; wrap one row, then narrow
        set_frame(10'h3FF, 5);
        frame_style = STYLE_UNIFORM;
        send_pixels(MAX_WIDTH_DEF + 1);
        drain_results();
        set_frame(5, 5);
        finish_frame();
        drain_results();

        // tallest height, then cut the frame short and narrow it mid-row
        set_frame(8, 13'h1FFF);
        frame_style = STYLE_HSTEP;
        edge_pos    = 6;
        send_pixels(59);
        drain_results();
        set_frame(5, 5);
        finish_frame();
        drain_results();

        directed_items = items_sent;
        rand_done      = 0;
        while (rand_done < RANDOM_ITEMS)
        begin
            if (rand_done < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 30;
                recv_idle_pct = 60;
            end
            else if (rand_done < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 60;
                recv_idle_pct = 30;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case ($urandom_range(9))
                0:       width_raw = $urandom_range(4);
                1:       width_raw = $urandom_range(40, 17);
                default: width_raw = $urandom_range(16, 5);
            endcase
            case ($urandom_range(9))
                0:       height_raw = $urandom_range(4);
                1:       height_raw = $urandom_range(14, 10);
                default: height_raw = $urandom_range(9, 5);
            endcase
            // one big frame while the output is held off, so the input backs up
            if (!long_hold && rand_done >= RANDOM_ITEMS / 3)
            begin
                long_hold  = 1'b1;
                width_raw  = 16;
                height_raw = 8;
            end
            set_frame(width_raw, height_raw);
            frame_style = frame_style_t'($urandom_range(4));
            edge_pos    = $urandom_range(12, 1);
            noise_level = pixel_t'($urandom_range(255));

            if ($urandom_range(4) == 0)
            begin
                // resize mid-frame; the width only narrows so every column read was written
                send_pixels($urandom_range(width_used * height_used - 1, 1));
                drain_results();
                set_frame($urandom_range(width_used), $urandom_range(12));
                if (pos_col != 0 || pos_row != 0)
                    finish_frame();
            end
            else
            begin
                finish_frame();
            end
            drain_results();
            rand_done = items_sent - directed_items;
        end

        $display("Checked %0d edge magnitudes from %0d pixels in %0d frames,",
                 results_seen, items_sent, frames_sent);
        $display("from clamped 5x5 up to 512-wide rows, with mid-frame resizes and hold-offs.");
        if (fail_count == 0 && pending == 0)
            $display("** sobel_5x5_edge_magnitude_core: PASSED **");
        else
            $display("** sobel_5x5_edge_magnitude_core: FAILED **");
        $finish;
    end

endmodule

/* files.f */
rtl/core/sobel5_pkg.sv
rtl/core/sobel5_line_mem.sv
rtl/core/sobel5_grad.sv
rtl/core/sobel5_isqrt.sv
rtl/core/sobel_5x5_edge_magnitude_core.sv
test/sobel5_magnitude_checker.sv
test/sobel_5x5_edge_magnitude_core_test.sv
